// ===== design/pmx_pkg.sv =====
// Shared types and constants of the partially mapped crossover engine.
`default_nettype none

package pmx_pkg;

    localparam int CITY_W    = 6;
    localparam int NUM_CODES = 1 << CITY_W;
    localparam int CNT_W     = 7;

    localparam logic [CNT_W-1:0] MIN_CITIES     = 7'd2;
    localparam logic [CNT_W-1:0] NUM_CITIES_RST = 7'd64;

    typedef logic [CITY_W-1:0] city_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef struct packed {
        logic  clear;
        logic  write;
        city_t look_one;
        city_t look_two;
    } map_ctrl_t;

    typedef struct packed {
        logic  hit_one;
        logic  hit_two;
        city_t val_one;
        city_t val_two;
    } map_stat_t;

endpackage

`default_nettype wire

// ===== design/pmx_crossover_engine_top.sv =====
// Top level of the partially mapped crossover engine.
//
// Each transfer on the s_ channel writes one position of both parent tours.
// The transfer whose position equals the tour length minus one also carries
// the two cut points and starts the crossover; other transfers only store.
// The cut points are ordered and clamped to the tour before use.
// The tour length must be written on the cfg_ channel only while the block
// is idle; the block itself does not enforce this. Loading takes one transfer
// per cycle while the block is idle. After the final transfer the block
// builds the mapping tables, reading and then writing each segment position.
// Each result outside the segment then walks its mapping chain, bounded in
// steps by the tour length. Both children walk their chains together through
// one table lookup unit, so the longer chain sets the rate.
// Results leave on the m_ channel one position at a time, position 0 first,
// with m_tlast on the final position. A stalled receiver holds the output
// register and the sequencer waits; s_tready is low while results are made.
// Reset empties the output register, returns to idle and sets the tour
// length to 64; parent contents are undefined until written.

`default_nettype none

module pmx_crossover_engine_top #(
    parameter int MAX_CITIES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // position, gene_first, gene_second, cut_a, cut_b
    input  wire logic [31:0] s_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_position, child_one_gene, child_two_gene
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    pmx_pkg::city_t     position;
    pmx_pkg::city_t     gene_first;
    pmx_pkg::city_t     gene_second;
    pmx_pkg::city_t     cut_a;
    pmx_pkg::city_t     cut_b;
    logic               store_en;
    pmx_pkg::city_t     rd_index;
    pmx_pkg::city_t     first_gene;
    pmx_pkg::city_t     second_gene;
    pmx_pkg::map_ctrl_t map_ctrl;
    pmx_pkg::map_stat_t map_stat;
    pmx_pkg::city_t     out_position;
    pmx_pkg::city_t     child_one_gene;
    pmx_pkg::city_t     child_two_gene;

    assign position    = s_tdata[5:0];
    assign gene_first  = s_tdata[11:6];
    assign gene_second = s_tdata[17:12];
    assign cut_a       = s_tdata[23:18];
    assign cut_b       = s_tdata[29:24];

    assign store_en = s_tvalid && s_tready && ({1'b0, position} < 7'(MAX_CITIES));

    pmx_parent_mem #(
        .DEPTH(MAX_CITIES)
    ) u_first_mem (
        .aclk     (aclk),
        .wr_en    (store_en),
        .wr_index (position),
        .wr_gene  (gene_first),
        .rd_index (rd_index),
        .rd_gene  (first_gene)
    );

    pmx_parent_mem #(
        .DEPTH(MAX_CITIES)
    ) u_second_mem (
        .aclk     (aclk),
        .wr_en    (store_en),
        .wr_index (position),
        .wr_gene  (gene_second),
        .rd_index (rd_index),
        .rd_gene  (second_gene)
    );

    pmx_map_table u_map (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .map_ctrl    (map_ctrl),
        .first_gene  (first_gene),
        .second_gene (second_gene),
        .map_stat    (map_stat)
    );

    pmx_seq #(
        .MAX_CITIES(MAX_CITIES)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_position  (position),
        .in_cut_a     (cut_a),
        .in_cut_b     (cut_b),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .rd_index     (rd_index),
        .first_gene   (first_gene),
        .second_gene  (second_gene),
        .map_ctrl     (map_ctrl),
        .map_stat     (map_stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_position (out_position),
        .out_gene_one (child_one_gene),
        .out_gene_two (child_two_gene),
        .out_last     (m_tlast)
    );

    assign m_tdata = {6'd0, child_two_gene, child_one_gene, out_position};

endmodule

`default_nettype wire

// ===== design/pmx_parent_mem.sv =====
// Parent tour store with one write port and one registered read port.
`default_nettype none

module pmx_parent_mem #(
    parameter int DEPTH = 64
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire pmx_pkg::city_t wr_index,
    input  wire pmx_pkg::city_t wr_gene,
    input  wire pmx_pkg::city_t rd_index,
    output pmx_pkg::city_t      rd_gene
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pmx_pkg::city_t gene_mem [DEPTH];
    pmx_pkg::city_t rd_gene_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            gene_mem[wr_index[AW-1:0]] <= wr_gene;
        end
        rd_gene_reg <= gene_mem[rd_index[AW-1:0]];
    end

    assign rd_gene = rd_gene_reg;

endmodule

`default_nettype wire

// ===== design/pmx_map_table.sv =====
// Segment mapping tables for both children with per-city hit bits.
`default_nettype none

module pmx_map_table (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pmx_pkg::map_ctrl_t map_ctrl,
    input  wire pmx_pkg::city_t     first_gene,
    input  wire pmx_pkg::city_t     second_gene,
    output pmx_pkg::map_stat_t      map_stat
);

    logic [pmx_pkg::NUM_CODES-1:0] hit_one_reg;
    logic [pmx_pkg::NUM_CODES-1:0] hit_two_reg;
    pmx_pkg::city_t map_one_mem [pmx_pkg::NUM_CODES];
    pmx_pkg::city_t map_two_mem [pmx_pkg::NUM_CODES];
    pmx_pkg::city_t val_one_reg;
    pmx_pkg::city_t val_two_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_one_reg <= '0;
            hit_two_reg <= '0;
        end else if (map_ctrl.clear) begin
            hit_one_reg <= '0;
            hit_two_reg <= '0;
        end else if (map_ctrl.write) begin
            hit_one_reg[second_gene] <= 1'b1;
            hit_two_reg[first_gene]  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (map_ctrl.write) begin
            map_one_mem[second_gene] <= first_gene;
            map_two_mem[first_gene]  <= second_gene;
        end
        val_one_reg <= map_one_mem[map_ctrl.look_one];
        val_two_reg <= map_two_mem[map_ctrl.look_two];
    end

    assign map_stat.hit_one = hit_one_reg[map_ctrl.look_one];
    assign map_stat.hit_two = hit_two_reg[map_ctrl.look_two];
    assign map_stat.val_one = val_one_reg;
    assign map_stat.val_two = val_two_reg;

endmodule

`default_nettype wire

// ===== design/pmx_seq.sv =====
// Sequencer that builds the segment mapping and walks the mapping chains.
`default_nettype none

module pmx_seq #(
    parameter int MAX_CITIES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pmx_pkg::city_t     in_position,
    input  wire pmx_pkg::city_t     in_cut_a,
    input  wire pmx_pkg::city_t     in_cut_b,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire pmx_pkg::count_t    cfg_data,
    output pmx_pkg::city_t          rd_index,
    input  wire pmx_pkg::city_t     first_gene,
    input  wire pmx_pkg::city_t     second_gene,
    output pmx_pkg::map_ctrl_t      map_ctrl,
    input  wire pmx_pkg::map_stat_t map_stat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pmx_pkg::city_t          out_position,
    output pmx_pkg::city_t          out_gene_one,
    output pmx_pkg::city_t          out_gene_two,
    output logic                    out_last
);

    localparam pmx_pkg::count_t MAX_N = pmx_pkg::count_t'(MAX_CITIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD_RD,
        ST_BUILD_WR,
        ST_POS_RD,
        ST_POS_EVAL,
        ST_CHAIN_RD,
        ST_CHAIN_UPD,
        ST_OUT
    } state_t;

    state_t          state_reg;
    pmx_pkg::count_t num_cities_reg;
    pmx_pkg::city_t  low_reg;
    pmx_pkg::city_t  high_reg;
    pmx_pkg::city_t  seg_idx_reg;
    pmx_pkg::city_t  pos_idx_reg;
    pmx_pkg::city_t  gene_one_reg;
    pmx_pkg::city_t  gene_two_reg;
    logic            act_one_reg;
    logic            act_two_reg;
    pmx_pkg::count_t steps_reg;
    logic            out_valid_reg;
    pmx_pkg::city_t  out_position_reg;
    pmx_pkg::city_t  out_gene_one_reg;
    pmx_pkg::city_t  out_gene_two_reg;
    logic            out_last_reg;

    pmx_pkg::count_t tour_len;
    pmx_pkg::city_t  last_pos;
    pmx_pkg::city_t  cut_lo;
    pmx_pkg::city_t  cut_hi;
    pmx_pkg::city_t  cut_lo_clamp;
    pmx_pkg::city_t  cut_hi_clamp;
    logic            accept;
    logic            start;
    logic            in_seg;
    logic            act_one;
    logic            act_two;
    logic            out_load;

    always_comb begin
        if (num_cities_reg < pmx_pkg::MIN_CITIES) begin
            tour_len = pmx_pkg::MIN_CITIES;
        end else if (num_cities_reg > MAX_N) begin
            tour_len = MAX_N;
        end else begin
            tour_len = num_cities_reg;
        end
    end

    assign last_pos     = pmx_pkg::city_t'(tour_len - 7'd1);
    assign cut_lo       = (in_cut_a < in_cut_b) ? in_cut_a : in_cut_b;
    assign cut_hi       = (in_cut_a < in_cut_b) ? in_cut_b : in_cut_a;
    assign cut_lo_clamp = (cut_lo > last_pos) ? last_pos : cut_lo;
    assign cut_hi_clamp = (cut_hi > last_pos) ? last_pos : cut_hi;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign start     = accept && (in_position == last_pos);

    assign in_seg   = (pos_idx_reg >= low_reg) && (pos_idx_reg <= high_reg);
    assign act_one  = map_stat.hit_one && (steps_reg < tour_len);
    assign act_two  = map_stat.hit_two && (steps_reg < tour_len);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    assign rd_index = (state_reg == ST_BUILD_RD) ? seg_idx_reg : pos_idx_reg;

    assign map_ctrl.clear    = start;
    assign map_ctrl.write    = (state_reg == ST_BUILD_WR);
    assign map_ctrl.look_one = gene_one_reg;
    assign map_ctrl.look_two = gene_two_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_cities_reg <= pmx_pkg::NUM_CITIES_RST;
            low_reg        <= '0;
            high_reg       <= '0;
            seg_idx_reg    <= '0;
            pos_idx_reg    <= '0;
            act_one_reg    <= 1'b0;
            act_two_reg    <= 1'b0;
            steps_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                num_cities_reg <= cfg_data;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        low_reg     <= cut_lo_clamp;
                        high_reg    <= cut_hi_clamp;
                        seg_idx_reg <= cut_lo_clamp;
                        state_reg   <= ST_BUILD_RD;
                    end
                end
                ST_BUILD_RD: begin
                    state_reg <= ST_BUILD_WR;
                end
                ST_BUILD_WR: begin
                    if (seg_idx_reg == high_reg) begin
                        pos_idx_reg <= '0;
                        state_reg   <= ST_POS_RD;
                    end else begin
                        seg_idx_reg <= seg_idx_reg + 6'd1;
                        state_reg   <= ST_BUILD_RD;
                    end
                end
                ST_POS_RD: begin
                    state_reg <= ST_POS_EVAL;
                end
                ST_POS_EVAL: begin
                    steps_reg <= '0;
                    if (in_seg) begin
                        gene_one_reg <= second_gene;
                        gene_two_reg <= first_gene;
                        state_reg    <= ST_OUT;
                    end else begin
                        gene_one_reg <= first_gene;
                        gene_two_reg <= second_gene;
                        state_reg    <= ST_CHAIN_RD;
                    end
                end
                ST_CHAIN_RD: begin
                    act_one_reg <= act_one;
                    act_two_reg <= act_two;
                    if (act_one || act_two) begin
                        steps_reg <= steps_reg + 7'd1;
                        state_reg <= ST_CHAIN_UPD;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_CHAIN_UPD: begin
                    if (act_one_reg) begin
                        gene_one_reg <= map_stat.val_one;
                    end
                    if (act_two_reg) begin
                        gene_two_reg <= map_stat.val_two;
                    end
                    state_reg <= ST_CHAIN_RD;
                end
                ST_OUT: begin
                    if (out_load) begin
                        out_position_reg <= pos_idx_reg;
                        out_gene_one_reg <= gene_one_reg;
                        out_gene_two_reg <= gene_two_reg;
                        out_last_reg     <= (pos_idx_reg == last_pos);
                        if (pos_idx_reg == last_pos) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            pos_idx_reg <= pos_idx_reg + 6'd1;
                            state_reg   <= ST_POS_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_position = out_position_reg;
    assign out_gene_one = out_gene_one_reg;
    assign out_gene_two = out_gene_two_reg;
    assign out_last     = out_last_reg;

endmodule

`default_nettype wire

// ===== design/pmx_chk.sv =====
// Port checker for the crossover engine and its bind to the top level.
`default_nettype none

module pmx_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled result keeps its contents until the transfer completes.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A waiting input transfer keeps its contents until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input changed while waiting");

    // While a child is only partly delivered no new parent data is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a child");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind pmx_crossover_engine_top pmx_chk u_pmx_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

`default_nettype wire

// ===== test/pmx_crossover_engine_top_tb.sv =====
// Self-checking testbench of the partially mapped crossover engine with its own crossover predictor.
`default_nettype none

module pmx_crossover_engine_top_tb;

    localparam int TOUR_MAX      = 64;
    localparam int RANDOM_LOADS  = 140;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 5000000;

    typedef struct packed {
        pmx_pkg::city_t pos;
        pmx_pkg::city_t one;
        pmx_pkg::city_t two;
        logic           last;
    } child_gene_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    pmx_pkg::city_t  parent_one [TOUR_MAX];
    pmx_pkg::city_t  parent_two [TOUR_MAX];
    int              seg_lo = 0;
    int              seg_hi = 0;
    pmx_pkg::count_t length_reg = pmx_pkg::NUM_CITIES_RST;
    child_gene_t     child_genes_due [$];
    child_gene_t     due_gene;

    bit src_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    int sink_wait = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int results_seen = 0;
    int loads_sent = 0;
    int tours_done = 0;

    pmx_crossover_engine_top #(
        .MAX_CITIES(TOUR_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Run stopped after %0d cycles without finishing.", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) cycle_count++;

    function automatic pmx_pkg::city_t rand_city();
        return pmx_pkg::city_t'($urandom_range(0, 63));
    endfunction

    function automatic int tour_span(pmx_pkg::count_t raw);
        if (raw < pmx_pkg::MIN_CITIES) return int'(pmx_pkg::MIN_CITIES);
        if (raw > TOUR_MAX) return TOUR_MAX;
        return int'(raw);
    endfunction

    function automatic pmx_pkg::city_t follow_map(pmx_pkg::city_t gene, bit key_second,
                                                  int span);
        pmx_pkg::city_t g;
        int             step;
        int             j;
        bit             hit;
        g = gene;
        for (step = 0; step < span; step++) begin
            hit = 1'b0;
            for (j = seg_hi; j >= seg_lo; j--) begin
                if ((key_second ? parent_two[j] : parent_one[j]) == g) begin
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit) break;
            g = key_second ? parent_one[j] : parent_two[j];
        end
        return g;
    endfunction

    function automatic void absorb_load(pmx_pkg::city_t pos, pmx_pkg::city_t g_one,
                                        pmx_pkg::city_t g_two, pmx_pkg::city_t cut_a,
                                        pmx_pkg::city_t cut_b);
        int          span;
        int          lo;
        int          hi;
        int          tmp;
        int          i;
        child_gene_t kid;
        span = tour_span(length_reg);
        parent_one[pos] = g_one;
        parent_two[pos] = g_two;
        if (int'(pos) != span - 1) return;
        lo = int'(cut_a);
        hi = int'(cut_b);
        if (lo > hi) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
        end
        if (lo > span - 1) lo = span - 1;
        if (hi > span - 1) hi = span - 1;
        seg_lo = lo;
        seg_hi = hi;
        for (i = 0; i < span; i++) begin
            kid.pos = pmx_pkg::city_t'(i);
            if (i >= seg_lo && i <= seg_hi) begin
                kid.one = parent_two[i];
                kid.two = parent_one[i];
            end else begin
                kid.one = follow_map(parent_one[i], 1'b1, span);
                kid.two = follow_map(parent_two[i], 1'b0, span);
            end
            kid.last = (i == span - 1);
            child_genes_due.push_back(kid);
        end
        tours_done++;
    endfunction

    task automatic check_field(input string what, input logic [5:0] want, input logic [5:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 60)
                $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready = 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            sink_wait = sink_gaps ? $urandom_range(0, 18) : 0;
            if (child_genes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 60)
                    $display("%0t: result at position %0d with none expected",
                             $time, m_tdata[5:0]);
            end else begin
                due_gene = child_genes_due.pop_front();
                check_field("out_position", due_gene.pos, m_tdata[5:0]);
                check_field("child_one_gene", due_gene.one, m_tdata[11:6]);
                check_field("child_two_gene", due_gene.two, m_tdata[17:12]);
                check_field("last", {5'd0, due_gene.last}, {5'd0, m_tlast});
            end
        end
    end

    task automatic send_gene(input pmx_pkg::city_t pos, input pmx_pkg::city_t g_one,
                             input pmx_pkg::city_t g_two, input pmx_pkg::city_t cut_a,
                             input pmx_pkg::city_t cut_b);
        int gap;
        gap = src_gaps ? $urandom_range(0, 18) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {2'b00, cut_b, cut_a, g_two, g_one, pos};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        absorb_load(pos, g_one, g_two, cut_a, cut_b);
        loads_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (child_genes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(input pmx_pkg::count_t raw);
        wait_drained();
        @(negedge aclk);
        cfg_data = raw;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        length_reg = raw;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Loads every position below the final one plus noise loads, then the final item with the cuts.
    task automatic run_tour(input bit well_formed, input int noise_pct, output int items);
        pmx_pkg::city_t one [TOUR_MAX];
        pmx_pkg::city_t two [TOUR_MAX];
        pmx_pkg::city_t tmp;
        int             order [TOUR_MAX];
        int             span;
        int             i;
        int             k;
        int             p;
        pmx_pkg::city_t cut_a;
        pmx_pkg::city_t cut_b;
        items = 0;
        span = tour_span(length_reg);
        for (i = 0; i < TOUR_MAX; i++) one[i] = pmx_pkg::city_t'(i);
        for (i = TOUR_MAX - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = one[i];
            one[i] = one[k];
            one[k] = tmp;
        end
        if (well_formed) begin
            for (i = 0; i < span; i++) two[i] = one[i];
            for (i = span - 1; i > 0; i--) begin
                k = $urandom_range(0, i);
                tmp = two[i];
                two[i] = two[k];
                two[k] = tmp;
            end
        end else begin
            for (i = 0; i < span; i++) begin
                one[i] = $urandom_range(0, 1) ? pmx_pkg::city_t'($urandom_range(0, 3))
                                              : rand_city();
                two[i] = $urandom_range(0, 1) ? pmx_pkg::city_t'($urandom_range(0, 3))
                                              : rand_city();
            end
        end
        for (i = 0; i < span - 1; i++) order[i] = i;
        if ($urandom_range(0, 1)) begin
            for (i = span - 2; i > 0; i--) begin
                k = $urandom_range(0, i);
                p = order[i];
                order[i] = order[k];
                order[k] = p;
            end
        end
        for (i = 0; i < span - 1; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                p = $urandom_range(0, 63);
                if (p == span - 1) p = (p + 1) % TOUR_MAX;
                send_gene(pmx_pkg::city_t'(p), rand_city(), rand_city(), rand_city(),
                          rand_city());
                items++;
            end
            send_gene(pmx_pkg::city_t'(order[i]), one[order[i]], two[order[i]],
                      rand_city(), rand_city());
            items++;
        end
        if ($urandom_range(0, 9) < 7) begin
            cut_a = pmx_pkg::city_t'($urandom_range(0, span - 1));
            cut_b = pmx_pkg::city_t'($urandom_range(0, span - 1));
        end else begin
            cut_a = rand_city();
            cut_b = rand_city();
        end
        send_gene(pmx_pkg::city_t'(span - 1), one[span - 1], two[span - 1], cut_a, cut_b);
        items++;
    endtask

    task automatic test_reset_length();
        int got;
        run_tour(1'b1, 0, got);
    endtask

    task automatic test_directed_cases();
        write_length(7'd0);
        send_gene(6'd0, 6'd63, 6'd0, 6'd0, 6'd0);
        send_gene(6'd5, 6'd1, 6'd2, 6'd3, 6'd4);
        send_gene(6'd1, 6'd0, 6'd63, 6'd63, 6'd0);

        write_length(7'd1);
        send_gene(6'd0, 6'd10, 6'd20, 6'd0, 6'd0);
        send_gene(6'd1, 6'd20, 6'd10, 6'd1, 6'd1);

        write_length(7'd2);
        send_gene(6'd1, 6'd63, 6'd63, 6'd1, 6'd0);

        write_length(7'd6);
        send_gene(6'd0, 6'd1, 6'd3, 6'd0, 6'd0);
        send_gene(6'd1, 6'd2, 6'd6, 6'd0, 6'd0);
        send_gene(6'd2, 6'd3, 6'd1, 6'd0, 6'd0);
        send_gene(6'd3, 6'd4, 6'd2, 6'd0, 6'd0);
        send_gene(6'd4, 6'd5, 6'd5, 6'd0, 6'd0);
        send_gene(6'd5, 6'd6, 6'd4, 6'd4, 6'd1);

        // Repeated cities form a closed mapping loop, so the chain runs to its bound.
        send_gene(6'd0, 6'd63, 6'd0, 6'd0, 6'd0);
        send_gene(6'd1, 6'd7, 6'd9, 6'd0, 6'd0);
        send_gene(6'd2, 6'd9, 6'd7, 6'd0, 6'd0);
        send_gene(6'd3, 6'd7, 6'd9, 6'd0, 6'd0);
        send_gene(6'd4, 6'd7, 6'd9, 6'd0, 6'd0);
        send_gene(6'd5, 6'd7, 6'd9, 6'd3, 6'd2);

        send_gene(6'd5, 6'd0, 6'd63, 6'd50, 6'd40);
    endtask

    task automatic test_length_limits();
        write_length(7'd127);
        send_gene(6'd63, rand_city(), rand_city(), 6'd0, 6'd63);
        write_length(7'd65);
        send_gene(6'd63, rand_city(), rand_city(), 6'd63, 6'd63);
        write_length(7'd64);
        send_gene(6'd63, rand_city(), rand_city(), 6'd20, 6'd5);
    endtask

    task automatic test_backpressure();
        int got;
        write_length(7'd24);
        src_gaps = 1'b0;
        run_tour(1'b1, 0, got);
        hold_cycles = 600;
        run_tour(1'b1, 0, got);
        wait_drained();
        src_gaps = 1'b1;
    endtask

    task automatic test_random_tours();
        int              sent;
        int              got;
        int              pick;
        pmx_pkg::count_t raw;
        sent = 0;
        while (sent < RANDOM_LOADS) begin
            if (sent == 0 || $urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    raw = pmx_pkg::count_t'($urandom_range(2, 12));
                else if (pick < 85)
                    raw = pmx_pkg::count_t'($urandom_range(13, 40));
                else if (pick < 91)
                    raw = pmx_pkg::count_t'($urandom_range(41, 64));
                else if (pick < 94)
                    raw = pmx_pkg::count_t'($urandom_range(0, 1));
                else
                    raw = pmx_pkg::count_t'($urandom_range(65, 127));
                write_length(raw);
            end
            src_gaps = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            run_tour($urandom_range(0, 4) != 0, 8, got);
            sent += got;
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_length();
        test_directed_cases();
        test_length_limits();
        test_backpressure();
        test_random_tours();
        wait_drained();
        $display("Crossovers run: %0d from %0d loads; child positions compared: %0d.",
                 tours_done, loads_sent, results_seen);
        $display("Tour lengths 2 to 64 with out-of-range settings, cut swap and clamp, %s",
                 "repeated cities and a long output stall were exercised.");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
